@@ hw/rtl/rsgt_pkg.sv @@
package rsgt_pkg;

   // register indexes on the csr port
   typedef enum logic [1:0] {
      REG_SAMPLE_LOW   = 2'd0,
      REG_SAMPLE_HIGH  = 2'd1,
      REG_QUIET_MS     = 2'd2,
      REG_BLOCK_LENGTH = 2'd3
   } csr_index_type;

   localparam int SAMPLE_W = 16;
   localparam int COUNT_W  = 12;
   localparam int FRAC_W   = 8;
   localparam int GATE_W   = SAMPLE_W + FRAC_W;   // q16.8
   localparam int ACC_W    = GATE_W + 4;          // 9*gate + run<<8 stays below 2^28

   localparam logic [SAMPLE_W-1:0] SAMPLE_LOW_RESET   = 16'd500;
   localparam logic [SAMPLE_W-1:0] SAMPLE_HIGH_RESET  = 16'd3500;
   localparam logic [SAMPLE_W-1:0] QUIET_MS_RESET     = 16'd20;
   localparam logic [COUNT_W-1:0]  BLOCK_LENGTH_RESET = 12'd1000;
   localparam logic [SAMPLE_W-1:0] RUN_MIN_RESET      = 16'hffff;

   // ceil(2^32 / 10); exact floor division for dividends below 2^30
   localparam int                 RECIP_W     = 29;
   localparam int                 RECIP_SHIFT = 32;
   localparam logic [RECIP_W-1:0] DIV10_RECIP = 29'd429496730;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [SAMPLE_W-1:0] ms_since_event;
   } req_type;

   typedef struct packed {
      logic                accepted;
      logic [SAMPLE_W-1:0] gate_min;
      logic [SAMPLE_W-1:0] gate_max;
   } rsp_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_low;
      logic [SAMPLE_W-1:0] sample_high;
      logic [SAMPLE_W-1:0] quiet_ms;
      logic [COUNT_W-1:0]  block_length;
   } cfg_type;

endpackage

@@ hw/rtl/rsgt_csr.sv @@
module rsgt_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  rsgt_pkg::csr_index_type         csr_index,
   input  logic [rsgt_pkg::SAMPLE_W-1:0]   csr_data,
   output rsgt_pkg::cfg_type               cfg
);

   rsgt_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            rsgt_pkg::REG_SAMPLE_LOW:   cfg_in.sample_low   = csr_data;
            rsgt_pkg::REG_SAMPLE_HIGH:  cfg_in.sample_high  = csr_data;
            rsgt_pkg::REG_QUIET_MS:     cfg_in.quiet_ms     = csr_data;
            rsgt_pkg::REG_BLOCK_LENGTH: cfg_in.block_length = csr_data[rsgt_pkg::COUNT_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_low   <= rsgt_pkg::SAMPLE_LOW_RESET;
         cfg_ff.sample_high  <= rsgt_pkg::SAMPLE_HIGH_RESET;
         cfg_ff.quiet_ms     <= rsgt_pkg::QUIET_MS_RESET;
         cfg_ff.block_length <= rsgt_pkg::BLOCK_LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hw/rtl/rsgt_smooth.sv @@
module rsgt_smooth (
   input  logic [rsgt_pkg::GATE_W-1:0]   gate,
   input  logic [rsgt_pkg::SAMPLE_W-1:0] run,
   output logic [rsgt_pkg::GATE_W-1:0]   gate_next
);

   localparam int PROD_W = rsgt_pkg::ACC_W + rsgt_pkg::RECIP_W;

   logic [rsgt_pkg::ACC_W-1:0] gate_ext;
   logic [rsgt_pkg::ACC_W-1:0] run_ext;
   logic [rsgt_pkg::ACC_W-1:0] acc;
   logic [PROD_W-1:0]          prod;

   // 9*gate + run in q16.8, then divide by ten via reciprocal multiply
   assign gate_ext  = {4'b0, gate};
   assign run_ext   = {4'b0, run, {rsgt_pkg::FRAC_W{1'b0}}};
   assign acc       = (gate_ext << 3) + gate_ext + run_ext;
   assign prod      = {{rsgt_pkg::RECIP_W{1'b0}}, acc}
                    * {{rsgt_pkg::ACC_W{1'b0}}, rsgt_pkg::DIV10_RECIP};
   assign gate_next = prod[rsgt_pkg::RECIP_SHIFT +: rsgt_pkg::GATE_W];

endmodule

@@ hw/rtl/random_sample_gate_tracker.sv @@
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_stall  | req_data  (sample, ms_since_event)
// rsp     | out       | rsp_valid/rsp_stall  | rsp_data  (accepted, gate_min, gate_max)
// csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// one transaction per cycle sustained while rsp_stall is low; a request passes the input
// register, then the output register; the rate rests on the tracker state (running
// min/max, count, gates) updating as a request moves out of the input register
// reset is synchronous: registers return to their defaults, gates to zero, warm-up restarts
// rsp_stall with both stages full stalls req in the same cycle; one request is still taken
// while a finished result waits
module random_sample_gate_tracker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  rsgt_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output rsgt_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  rsgt_pkg::csr_index_type        csr_index,
   input  logic [rsgt_pkg::SAMPLE_W-1:0]  csr_data
);

   rsgt_pkg::cfg_type cfg;

   // pipeline registers
   logic              in_valid_ff, in_valid_in;
   rsgt_pkg::req_type in_data_ff;
   logic              out_valid_ff, out_valid_in;
   rsgt_pkg::rsp_type out_data_ff, out_data_in;

   // tracker state
   logic [rsgt_pkg::SAMPLE_W-1:0] run_min_ff, run_min_in;
   logic [rsgt_pkg::SAMPLE_W-1:0] run_max_ff, run_max_in;
   logic [rsgt_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [rsgt_pkg::GATE_W-1:0]   smooth_min_ff, smooth_min_in;
   logic [rsgt_pkg::GATE_W-1:0]   smooth_max_ff, smooth_max_in;
   logic                          warmed_ff, warmed_in;

   logic                          req_take;
   logic                          advance;
   logic                          pass;
   logic [rsgt_pkg::COUNT_W-1:0]  len;
   logic [rsgt_pkg::COUNT_W-1:0]  count_inc;
   logic [rsgt_pkg::SAMPLE_W-1:0] min_upd, max_upd;
   logic                          block_done;
   logic [rsgt_pkg::GATE_W-1:0]   step_min, step_max;

   rsgt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // smoothing runs on the running values that include the current sample
   rsgt_smooth u_smooth_min (
      .gate      (smooth_min_ff),
      .run       (min_upd),
      .gate_next (step_min)
   );

   rsgt_smooth u_smooth_max (
      .gate      (smooth_max_ff),
      .run       (max_upd),
      .gate_next (step_max)
   );

   // handshake: the input stage moves on when the output register is free or drains
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // sample gating and block bookkeeping
   assign pass = (in_data_ff.sample >= cfg.sample_low)
              && (in_data_ff.sample <= cfg.sample_high)
              && (in_data_ff.ms_since_event >= cfg.quiet_ms);

   // a block length of zero behaves as one
   assign len        = (cfg.block_length == '0) ? rsgt_pkg::COUNT_W'(1) : cfg.block_length;
   assign count_inc  = count_ff + rsgt_pkg::COUNT_W'(1);
   assign min_upd    = (in_data_ff.sample < run_min_ff) ? in_data_ff.sample : run_min_ff;
   assign max_upd    = (in_data_ff.sample > run_max_ff) ? in_data_ff.sample : run_max_ff;
   assign block_done = (count_inc >= len);

   always_comb begin
      run_min_in    = run_min_ff;
      run_max_in    = run_max_ff;
      count_in      = count_ff;
      smooth_min_in = smooth_min_ff;
      smooth_max_in = smooth_max_ff;
      warmed_in     = warmed_ff;
      out_data_in   = out_data_ff;

      if (advance) begin
         // rejected samples leave the state alone and report zeros
         out_data_in = '0;
         if (pass) begin
            run_min_in           = min_upd;
            run_max_in           = max_upd;
            count_in             = count_inc;
            out_data_in.accepted = 1'b1;
            priority if (!warmed_ff && !block_done) begin
               // warm-up: report the running block values directly
               out_data_in.gate_min = min_upd;
               out_data_in.gate_max = max_upd;
            end else if (!warmed_ff) begin
               // first full block loads the gates
               smooth_min_in = {min_upd, {rsgt_pkg::FRAC_W{1'b0}}};
               smooth_max_in = {max_upd, {rsgt_pkg::FRAC_W{1'b0}}};
               warmed_in     = 1'b1;
            end else if (block_done) begin
               smooth_min_in = step_min;
               smooth_max_in = step_max;
            end else begin
               // mid-block after warm-up: gates hold
            end
            if (block_done) begin
               run_min_in = rsgt_pkg::RUN_MIN_RESET;
               run_max_in = '0;
               count_in   = '0;
            end
            if (warmed_ff || block_done) begin
               out_data_in.gate_min = smooth_min_in[rsgt_pkg::FRAC_W +: rsgt_pkg::SAMPLE_W];
               out_data_in.gate_max = smooth_max_in[rsgt_pkg::FRAC_W +: rsgt_pkg::SAMPLE_W];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         run_min_ff    <= rsgt_pkg::RUN_MIN_RESET;
         run_max_ff    <= '0;
         count_ff      <= '0;
         smooth_min_ff <= '0;
         smooth_max_ff <= '0;
         warmed_ff     <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         run_min_ff    <= run_min_in;
         run_max_ff    <= run_max_in;
         count_ff      <= count_in;
         smooth_min_ff <= smooth_min_in;
         smooth_max_ff <= smooth_max_in;
         warmed_ff     <= warmed_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      out_data_ff <= out_data_in;
   end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

   // clock and synchronous reset, held high at the start of the run
   logic clock;
   logic reset = 1'b1;

   // request side: one sample plus quiet time per transaction
   logic              req_valid = 1'b0;
   logic              req_stall;
   rsgt_pkg::req_type req_data  = '0;

   // result side: accept flag and the two gates
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsgt_pkg::rsp_type rsp_data;

   // register write port
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   rsgt_pkg::csr_index_type csr_index = rsgt_pkg::REG_SAMPLE_LOW;
   logic [15:0]             csr_data  = '0;

   random_sample_gate_tracker dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // shadow copy of the registers, tracking every accepted csr write
   logic [15:0] win_low   = rsgt_pkg::SAMPLE_LOW_RESET;
   logic [15:0] win_high  = rsgt_pkg::SAMPLE_HIGH_RESET;
   logic [15:0] min_quiet = rsgt_pkg::QUIET_MS_RESET;
   logic [11:0] blk_len   = rsgt_pkg::BLOCK_LENGTH_RESET;

   // shadow copy of the tracker state
   logic [15:0] low_seen     = 16'hffff;
   logic [15:0] high_seen    = 16'h0000;
   logic [11:0] seen_count   = '0;
   logic [23:0] gate_lo_q    = '0;   // q16.8
   logic [23:0] gate_hi_q    = '0;   // q16.8
   logic        gates_loaded = 1'b0;

   // gate results still owed by the block, oldest first
   rsgt_pkg::rsp_type gates_due[$];
   rsgt_pkg::rsp_type want;

   int mismatches = 0;

   // idling knobs for the sender (gap) and the result stall process (stall, hold)
   int gap_pct         = 25;
   int stall_pct       = 25;
   int rsp_hold_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop well past the slowest legal run
   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

   // exponential smoothing in q16.8: (9*gate + run) / 10, truncated
   function automatic logic [23:0] ema_step(input logic [23:0] gate, input logic [15:0] run);
      logic [31:0] acc;
      acc = 32'd9 * gate + {8'h00, run, 8'h00};
      acc = acc / 32'd10;
      return acc[23:0];
   endfunction

   // advance the shadow tracker by one sample and return the gates it reports
   function automatic rsgt_pkg::rsp_type predict_gates(input rsgt_pkg::req_type item);
      rsgt_pkg::rsp_type res;
      logic [11:0]       eff_len;
      res     = '0;
      eff_len = (blk_len == 12'd0) ? 12'd1 : blk_len;
      // out of window or too soon after a panel event: all zero, state untouched
      if (item.sample < win_low || item.sample > win_high ||
          item.ms_since_event < min_quiet)
         return res;
      seen_count = seen_count + 12'd1;
      if (item.sample < low_seen) low_seen = item.sample;
      if (item.sample > high_seen) high_seen = item.sample;
      res.accepted = 1'b1;
      if (seen_count >= eff_len) begin
         if (gates_loaded) begin
            gate_lo_q = ema_step(gate_lo_q, low_seen);
            gate_hi_q = ema_step(gate_hi_q, high_seen);
         end else begin
            // first full block loads the gates directly
            gate_lo_q    = {low_seen, 8'h00};
            gate_hi_q    = {high_seen, 8'h00};
            gates_loaded = 1'b1;
         end
         low_seen   = 16'hffff;
         high_seen  = 16'h0000;
         seen_count = '0;
      end else if (!gates_loaded) begin
         // warm-up reports the running extremes
         res.gate_min = low_seen;
         res.gate_max = high_seen;
         return res;
      end
      res.gate_min = gate_lo_q[23:8];
      res.gate_max = gate_hi_q[23:8];
      return res;
   endfunction

   function automatic int idle_length();
      return ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
   endfunction

   // offer one transaction, hold it until taken, then maybe go idle for a while
   task automatic send_sample(input logic [15:0] s, input logic [15:0] ms);
      rsgt_pkg::req_type item;
      item.sample         = s;
      item.ms_since_event = ms;
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      gates_due.push_back(predict_gates(item));
      if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat (idle_length()) @(posedge clock);
      end
   endtask

   // stop offering and wait until every owed result has been checked
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (gates_due.size() != 0);
   endtask

   task automatic write_reg(input rsgt_pkg::csr_index_type idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         rsgt_pkg::REG_SAMPLE_LOW:   win_low   = value;
         rsgt_pkg::REG_SAMPLE_HIGH:  win_high  = value;
         rsgt_pkg::REG_QUIET_MS:     min_quiet = value;
         rsgt_pkg::REG_BLOCK_LENGTH: blk_len   = value[11:0];
         default: ;
      endcase
   endtask

   // only called with the block drained
   task automatic configure(input logic [15:0] lo, input logic [15:0] hi,
                            input logic [15:0] quiet, input logic [15:0] len);
      write_reg(rsgt_pkg::REG_SAMPLE_LOW, lo);
      write_reg(rsgt_pkg::REG_SAMPLE_HIGH, hi);
      write_reg(rsgt_pkg::REG_QUIET_MS, quiet);
      write_reg(rsgt_pkg::REG_BLOCK_LENGTH, len);
      csr_valid <= 1'b0;
   endtask

   // window edges and quiet threshold with the reset register values
   task automatic test_accept_window();
      send_sample(16'd499, 16'd100);
      send_sample(16'd500, 16'd20);
      send_sample(16'd3500, 16'd65535);
      send_sample(16'd3501, 16'd100);
      send_sample(16'd2000, 16'd19);
      send_sample(16'd0, 16'd100);
      send_sample(16'd65535, 16'd100);
      send_sample(16'd1000, 16'd20);
      wait_drained();
   endtask

   // widest window, strictest quiet time, and a window with low above high
   task automatic test_register_extremes();
      configure(16'd0, 16'd65535, 16'd0, 16'd1000);
      send_sample(16'd0, 16'd0);
      send_sample(16'd65535, 16'd0);
      wait_drained();
      configure(16'd0, 16'd65535, 16'd65535, 16'd1000);
      send_sample(16'd1234, 16'd65534);
      send_sample(16'd1234, 16'd65535);
      wait_drained();
      configure(16'd100, 16'd50, 16'd0, 16'd1000);
      send_sample(16'd75, 16'd1000);
      send_sample(16'd100, 16'd1000);
      send_sample(16'd50, 16'd1000);
      wait_drained();
   endtask

   // block length cut below the count ends warm-up on the next accepted sample
   task automatic test_block_shortened();
      configure(16'd0, 16'd65535, 16'd0, 16'd4095);
      send_sample(16'd300, 16'd5);
      send_sample(16'd40000, 16'd5);
      send_sample(16'd7, 16'd5);
      wait_drained();
      configure(16'd0, 16'd65535, 16'd0, 16'd2);
      send_sample(16'd100, 16'd5);
      wait_drained();
   endtask

   // length zero acts as one: every accepted sample closes a block
   task automatic test_zero_length();
      configure(16'd0, 16'd65535, 16'd0, 16'd0);
      send_sample(16'd0, 16'd0);
      send_sample(16'd65535, 16'd0);
      send_sample(16'd32768, 16'd0);
      wait_drained();
   endtask

   // phases of mostly in-window traffic under random register settings
   task automatic test_random_traffic();
      int          phase;
      logic [15:0] lo, hi, quiet, len, s, ms;
      phase = 0;
      repeat (7) begin
         case ($urandom_range(3))
            0: begin lo = 16'd0; hi = 16'd65535; end
            1: begin lo = 16'($urandom); hi = lo; end
            default: begin
               lo = 16'($urandom_range(30000));
               hi = lo + 16'($urandom_range(35535, 16));
            end
         endcase
         case ($urandom_range(5))
            0: quiet = 16'd0;
            1: quiet = 16'd65535;
            default: quiet = 16'($urandom_range(200));
         endcase
         case ($urandom_range(5))
            0: len = 16'd0;
            1: len = 16'($urandom_range(60, 20));
            // upper csr bits are outside the 12-bit length
            2: len = {4'($urandom_range(15)), 12'(1 + $urandom_range(4))};
            default: len = 16'($urandom_range(8, 1));
         endcase
         configure(lo, hi, quiet, len);
         // one phase runs flat out on both sides
         gap_pct   = (phase == 1) ? 0 : 30;
         stall_pct = (phase == 1) ? 0 : 30;
         repeat (80) begin
            if ($urandom_range(4) != 0) begin
               s  = 16'($urandom_range(hi, lo));
               ms = 16'($urandom_range(65535, quiet));
            end else begin
               s  = 16'($urandom);
               ms = 16'($urandom);
            end
            send_sample(s, ms);
         end
         wait_drained();
         phase++;
      end
   endtask

   // receiver holds off long enough for the block to fill and stall requests
   task automatic test_backpressure();
      configure(16'd0, 16'd65535, 16'd0, 16'd3);
      gap_pct   = 0;
      stall_pct = 0;
      rsp_hold_cycles = 200;
      repeat (30) send_sample(16'($urandom), 16'($urandom));
      // sender pauses until every result is back
      wait_drained();
      gap_pct   = 25;
      stall_pct = 25;
      repeat (20) send_sample(16'($urandom), 16'($urandom));
      wait_drained();
   endtask

   // result stall: random runs, or one long hold on request
   initial begin
      int hold;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            hold            = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
            rsp_stall <= 1'b1;
            repeat (idle_length()) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // every taken result is matched against the oldest owed one
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (gates_due.size() == 0) begin
            mismatches++;
            $display("%0t unexpected result: expected none, got accepted=%0d min=%0d max=%0d",
                     $time, rsp_data.accepted, rsp_data.gate_min, rsp_data.gate_max);
         end else begin
            want = gates_due.pop_front();
            if (rsp_data !== want) begin
               mismatches++;
               $display("%0t gate mismatch: expected accepted=%0d min=%0d max=%0d",
                        $time, want.accepted, want.gate_min, want.gate_max);
               $display("%0t                got accepted=%0d min=%0d max=%0d",
                        $time, rsp_data.accepted, rsp_data.gate_min, rsp_data.gate_max);
            end
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_accept_window();
      test_register_extremes();
      test_block_shortened();
      test_zero_length();
      test_random_traffic();
      test_backpressure();
      wait_drained();
      // settle time for any stray result after the drain
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

@@ random_sample_gate_tracker.f @@
hw/rtl/rsgt_pkg.sv
hw/rtl/rsgt_csr.sv
hw/rtl/rsgt_smooth.sv
hw/rtl/random_sample_gate_tracker.sv
tb/tb_top.sv
